FILE: rtl/positional_list_buffer_core_assert.svh
// Assertion macros shared by the positional list buffer modules.
`ifndef POSITIONAL_LIST_BUFFER_CORE_ASSERT_SVH
`define POSITIONAL_LIST_BUFFER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PLB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PLB_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PLB_ASSERT(lbl, prop, msg)
`define PLB_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

FILE: rtl/plb_pkg.sv
`timescale 1ns / 1ps
// Types, codes and command/status structs of the positional list buffer.
package plb_pkg;

    localparam int CMD_W     = 3;
    localparam int POS_W     = 7;
    localparam int WORD_W    = 64;
    localparam int CNT_OUT_W = 7;

    typedef enum logic [2:0] {
        CMD_APPEND    = 3'd0,
        CMD_INS_POS   = 3'd1,
        CMD_DEL_POS   = 3'd2,
        CMD_INS_MATCH = 3'd3,
        CMD_DEL_MATCH = 3'd4,
        CMD_READ      = 3'd5
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // Datapath activity selected by the controller in each cycle.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEARCH,
        PH_COMPACT,
        PH_UP,
        PH_DN,
        PH_READ,
        PH_PUT
    } phase_t;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_INC,
        CNT_DEC,
        CNT_LOAD_J
    } cnt_op_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] new_value;
        logic [WORD_W-1:0] match_value;
    } plb_req_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [CNT_OUT_W-1:0] entry_count;
        logic [WORD_W-1:0]    read_value;
    } plb_rsp_t;

    typedef struct packed {
        logic    capture;
        logic    start;
        phase_t  phase;
        cnt_op_t cnt_op;
        logic    res_load;
        status_t res_status;
        logic    res_rd;
    } plb_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             bad_ins;
        logic             bad_pos;
        logic             full;
        logic             found;
        logic             nomatch;
        logic             search_done;
        logic             compact_done;
        logic             up_done;
        logic             dn_done;
        logic             slot_free;
    } plb_stat_t;

endpackage

FILE: rtl/plb_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
module plb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/plb_dp.sv
`timescale 1ns / 1ps
// Datapath: item registers, entry memory, walk pointers, count and result register.
`include "positional_list_buffer_core_assert.svh"
module plb_dp
    import plb_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  plb_req_t  req,
    input  plb_cmd_t  cmd,
    output plb_stat_t stat,
    input  logic      rsp_ready,
    output logic      rsp_valid,
    output plb_rsp_t  rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [CMD_W-1:0]  op_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [WORD_W-1:0] nv_reg;
    logic [WORD_W-1:0] mv_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] src_reg, src_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] ins_reg, ins_next;
    logic          pend_reg, pend_next;
    logic          found_reg, found_next;
    logic          rsp_valid_reg, rsp_valid_next;
    plb_rsp_t      rsp_reg, rsp_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic [PW-1:0] pos_w;
    logic [PW-1:0] cnt_w;
    logic          iss_search;
    logic          iss_scan;
    logic          iss_up;
    logic          slot_free;

    plb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pos_w      = PW'(pos_reg);
    assign cnt_w      = PW'(count_reg);
    assign iss_search = (ptr_reg < count_reg) && !found_reg;
    assign iss_scan   = ptr_reg < count_reg;
    assign iss_up     = ptr_reg > ins_reg;
    assign slot_free  = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        stat.op           = op_reg;
        stat.bad_ins      = (pos_reg == '0) || (pos_w > cnt_w + PW'(1));
        stat.bad_pos      = (pos_reg == '0) || (pos_w > cnt_w);
        stat.full         = count_reg == CW'(CAPACITY);
        stat.found        = found_reg;
        stat.nomatch      = j_reg == count_reg;
        stat.search_done  = !iss_search && !pend_reg;
        stat.compact_done = !iss_scan && !pend_reg;
        stat.up_done      = !iss_up && !pend_reg;
        stat.dn_done      = !iss_scan && !pend_reg;
        stat.slot_free    = slot_free;
    end

    always_comb
    begin
        ram_re     = 1'b0;
        ram_raddr  = ptr_reg[AW-1:0];
        ram_we     = 1'b0;
        ram_waddr  = j_reg[AW-1:0];
        ram_wdata  = ram_rdata;
        ptr_next   = ptr_reg;
        src_next   = src_reg;
        pend_next  = 1'b0;
        j_next     = j_reg;
        found_next = found_reg;
        ins_next   = ins_reg;

        if (cmd.capture)
        begin
            if (req.cmd == CMD_APPEND)
            begin
                ins_next = count_reg;
            end
            else
            begin
                ins_next = CW'(PW'(req.position) - PW'(1));
            end
        end

        if (cmd.start)
        begin
            found_next = 1'b0;
            j_next     = '0;
            case (cmd.phase)
                PH_UP:   ptr_next = count_reg;
                PH_DN:   ptr_next = CW'(pos_reg);
                default: ptr_next = '0;
            endcase
        end
        else
        begin
            case (cmd.phase)
                PH_SEARCH:
                begin
                    ram_re    = iss_search;
                    pend_next = iss_search;
                    src_next  = ptr_reg;
                    if (iss_search)
                    begin
                        ptr_next = ptr_reg + CW'(1);
                    end
                    if (pend_reg && !found_reg && (ram_rdata == mv_reg))
                    begin
                        found_next = 1'b1;
                        ins_next   = src_reg + CW'(1);
                    end
                end
                PH_COMPACT:
                begin
                    ram_re    = iss_scan;
                    pend_next = iss_scan;
                    src_next  = ptr_reg;
                    if (iss_scan)
                    begin
                        ptr_next = ptr_reg + CW'(1);
                    end
                    // Survivors are packed down to the write pointer.
                    if (pend_reg && (ram_rdata != mv_reg))
                    begin
                        ram_we = 1'b1;
                        j_next = j_reg + CW'(1);
                    end
                end
                PH_UP:
                begin
                    // The pointer names the target slot; the source is one below.
                    ram_re    = iss_up;
                    ram_raddr = AW'(ptr_reg - CW'(1));
                    pend_next = iss_up;
                    src_next  = ptr_reg;
                    if (iss_up)
                    begin
                        ptr_next = ptr_reg - CW'(1);
                    end
                    if (pend_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = src_reg[AW-1:0];
                    end
                end
                PH_DN:
                begin
                    ram_re    = iss_scan;
                    pend_next = iss_scan;
                    src_next  = ptr_reg;
                    if (iss_scan)
                    begin
                        ptr_next = ptr_reg + CW'(1);
                    end
                    if (pend_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(src_reg - CW'(1));
                    end
                end
                PH_READ:
                begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(pos_w - PW'(1));
                end
                PH_PUT:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ins_reg[AW-1:0];
                    ram_wdata = nv_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cmd.cnt_op)
            CNT_INC:    count_next = count_reg + CW'(1);
            CNT_DEC:    count_next = count_reg - CW'(1);
            CNT_LOAD_J: count_next = j_reg;
            default:    count_next = count_reg;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (cmd.res_load)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.status      = cmd.res_status;
            rsp_next.entry_count = CNT_OUT_W'(count_reg);
            rsp_next.read_value  = cmd.res_rd ? ram_rdata : '0;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= req.cmd;
            pos_reg <= req.position;
            nv_reg  <= req.new_value;
            mv_reg  <= req.match_value;
        end
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            src_reg       <= '0;
            j_reg         <= '0;
            ins_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            src_reg       <= src_next;
            j_reg         <= j_next;
            ins_reg       <= ins_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `PLB_ASSERT(a_count_cap, (count_reg <= CW'(CAPACITY)), "entry count above capacity")
    `PLB_ASSERT_NEVER(a_rw_clash, ram_we && ram_re && (ram_waddr == ram_raddr), "read and write hit one address")
    `PLB_ASSERT(a_count_cmd, (count_reg != $past(count_reg)) |-> ($past(cmd.cnt_op) != CNT_KEEP), "count moved without a count command")

endmodule

FILE: rtl/plb_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences each item through check, walk, write and result phases.
`include "positional_list_buffer_core_assert.svh"
module plb_ctrl
    import plb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  plb_stat_t stat,
    output plb_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SEARCH,
        S_COMPACT,
        S_UP,
        S_DN,
        S_PUT,
        S_RD_ISSUE,
        S_FINISH
    } state_t;

    state_t  state_reg, state_next;
    status_t st_reg, st_next;
    logic    rd_ok_reg, rd_ok_next;

    assign req_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        rd_ok_next = rd_ok_reg;

        cmd            = '0;
        cmd.phase      = PH_IDLE;
        cmd.cnt_op     = CNT_KEEP;
        cmd.res_status = st_reg;
        cmd.res_rd     = rd_ok_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    st_next     = ST_OK;
                    rd_ok_next  = 1'b0;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (stat.op)
                    CMD_APPEND:
                    begin
                        if (stat.full)
                        begin
                            st_next    = ST_FULL;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_PUT;
                        end
                    end
                    CMD_INS_POS:
                    begin
                        if (stat.bad_ins)
                        begin
                            st_next    = ST_BADPOS;
                            state_next = S_FINISH;
                        end
                        else if (stat.full)
                        begin
                            st_next    = ST_FULL;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.start  = 1'b1;
                            cmd.phase  = PH_UP;
                            state_next = S_UP;
                        end
                    end
                    CMD_DEL_POS:
                    begin
                        if (stat.bad_pos)
                        begin
                            st_next    = ST_BADPOS;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.start  = 1'b1;
                            cmd.phase  = PH_DN;
                            state_next = S_DN;
                        end
                    end
                    CMD_INS_MATCH:
                    begin
                        cmd.start  = 1'b1;
                        cmd.phase  = PH_SEARCH;
                        state_next = S_SEARCH;
                    end
                    CMD_DEL_MATCH:
                    begin
                        cmd.start  = 1'b1;
                        cmd.phase  = PH_COMPACT;
                        state_next = S_COMPACT;
                    end
                    CMD_READ:
                    begin
                        if (stat.bad_pos)
                        begin
                            st_next    = ST_BADPOS;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_RD_ISSUE;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SEARCH:
            begin
                cmd.phase = PH_SEARCH;
                if (stat.search_done)
                begin
                    if (!stat.found)
                    begin
                        st_next    = ST_NOTFOUND;
                        state_next = S_FINISH;
                    end
                    else if (stat.full)
                    begin
                        st_next    = ST_FULL;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        cmd.phase  = PH_UP;
                        state_next = S_UP;
                    end
                end
            end
            S_COMPACT:
            begin
                cmd.phase = PH_COMPACT;
                if (stat.compact_done)
                begin
                    if (stat.nomatch)
                    begin
                        st_next = ST_NOTFOUND;
                    end
                    else
                    begin
                        cmd.cnt_op = CNT_LOAD_J;
                    end
                    state_next = S_FINISH;
                end
            end
            S_UP:
            begin
                cmd.phase = PH_UP;
                if (stat.up_done)
                begin
                    state_next = S_PUT;
                end
            end
            S_DN:
            begin
                cmd.phase = PH_DN;
                if (stat.dn_done)
                begin
                    cmd.cnt_op = CNT_DEC;
                    state_next = S_FINISH;
                end
            end
            S_PUT:
            begin
                cmd.phase  = PH_PUT;
                cmd.cnt_op = CNT_INC;
                state_next = S_FINISH;
            end
            S_RD_ISSUE:
            begin
                cmd.phase  = PH_READ;
                rd_ok_next = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.slot_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            rd_ok_reg <= rd_ok_next;
        end
    end

    `PLB_ASSERT(a_load_slot, cmd.res_load |-> stat.slot_free, "result loaded into a full slot")
    `PLB_ASSERT(a_start_hold, cmd.start |=> (cmd.phase == $past(cmd.phase)) && !cmd.start, "walk did not follow its start")
    `PLB_ASSERT_NEVER(a_capture_busy, cmd.capture && !req_ready, "item captured while busy")

endmodule

FILE: rtl/positional_list_buffer_core.sv
`timescale 1ns / 1ps
// Top level of the positional list buffer: controller, datapath and entry memory.
//
//   Channel  Signals                      Contents
//   req      req_valid / req_ready / req  command, position, new and match words
//   rsp      rsp_valid / rsp_ready / rsp  status, entry count after the command, read word
//
// One item is in work at a time. Append goes from acceptance through the decide, put
// and finish steps; read through decide, read issue and finish; a failed position
// check through decide and finish. Insert at position shifts the entries at and after
// the position up by one slot before the put, delete at position shifts the entries
// above it down by one slot, delete of all matches scans every entry and packs the
// survivors down, and insert after a match runs a search pass, then a shift pass.
// Each pass moves one entry per cycle through the memory's registered read port,
// so the walks set the rate. Reset clears the control state and sets the entry count
// to zero; the memory itself is not cleared. The next item is taken as soon as the
// controller is back in idle, even while the previous result still waits in the
// output register; a stalled result holds only the finish step of the following item.
module positional_list_buffer_core
    import plb_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  plb_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output plb_rsp_t rsp
);

    // Command and status groups between the controller and the datapath.
    plb_cmd_t  cmd;
    plb_stat_t stat;

    // The controller decides the walk for each item from the datapath's checks
    // and walks the datapath through it one phase at a time.
    plb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the item, the entry memory, the walk pointers, the count
    // and the output register that parts the result from the next item.
    plb_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule
